@@ design/blir_pkg.sv @@
// shared constants, codes and types of the bounded list block
package blir_pkg;

   // list capacity and derived widths
   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int VAL_W = 32;

   // operation codes carried in req_tuser
   localparam logic [1:0] ACT_APPEND    = 2'd0;
   localparam logic [1:0] ACT_REM_FIRST = 2'd1;
   localparam logic [1:0] ACT_REM_ALL   = 2'd2;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_HOLD
   } state_type;

   // per-cell control from the sequencer
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

endpackage

@@ design/blir_cell.sv @@
// one storage cell of the list chain: holds one entry, loads or takes its neighbor's entry
module blir_cell
   import blir_pkg::*;
(
   input  logic               clock,
   input  cell_ctl_type       ctl,
   input  logic [VAL_W-1:0]   load_data,
   input  logic [VAL_W-1:0]   right_data,
   output logic [VAL_W-1:0]   data
);

   logic [VAL_W-1:0] data_ff;
   logic [VAL_W-1:0] data_in;

   // a load wins over the shift toward the head
   always_comb begin
      if (ctl.load) begin
         data_in = load_data;
      end else if (ctl.shift) begin
         data_in = right_data;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

@@ design/bounded_list_insert_remove_top.sv @@
// top level of the bounded list: cell chain, scan sequencer and output register
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+--------------------------------------------
//  req     | in  | req_tvalid/tready    | tdata: value; tuser: action
//  rsp     | out | rsp_tvalid/tready    | tdata: removed_value, entry_count; tuser: flags
//
// append and the unused code pass through the hold state into the output register after the accept
// a removal first scans the entries counted at the accept, then passes through the hold state: the head entry leaves
// the chain once per cycle and is either dropped or written back behind the unscanned entries
// reset clears the entry count and the handshake state; entries are undefined until written
// a new item is taken while the previous result still waits on rsp; a stalled rsp
// holds the next result in the sequencer until the output register frees
module bounded_list_insert_remove_top
   import blir_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [1:0]  req_tuser,   // [1:0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] removed_value, [36:32] entry_count, [39:37] zero
   output logic [1:0]  rsp_tuser    // [0] found, [1] rejected
);

   state_type state_ff, state_in;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] n_ff;
   logic [CNT_W-1:0] k_ff;
   logic [CNT_W-1:0] r_ff;
   logic [1:0]       act_ff;
   logic [VAL_W-1:0] key_ff;
   logic             rej_ff;

   logic             rsp_valid_ff;
   logic [VAL_W-1:0] rsp_value_ff;
   logic [4:0]       rsp_count_ff;
   logic             rsp_found_ff;
   logic             rsp_rej_ff;

   logic             req_fire;
   logic             out_free;
   logic             scan_step;
   logic             scan_done;
   logic             hold_load;
   logic             full;
   logic             is_append;
   logic             is_removal;
   logic             match;
   logic             keep;
   logic [CNT_W-1:0] wr_pos;
   logic [VAL_W-1:0] head;
   logic [VAL_W-1:0] load_data;

   logic [VAL_W-1:0] cell_q [DEPTH];
   cell_ctl_type     cell_ctl [DEPTH];

   // handshake and decode
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign full       = (count_ff == CNT_W'(DEPTH));
   assign is_append  = (req_tuser == ACT_APPEND);
   assign is_removal = (act_ff == ACT_REM_FIRST) || (act_ff == ACT_REM_ALL);
   assign scan_done  = (k_ff == n_ff);

   // head entry test: drop it on a match, else write it back behind the unscanned ones
   assign head   = cell_q[0];
   assign match  = (head == key_ff) && ((act_ff == ACT_REM_ALL) || (r_ff == '0));
   assign keep   = !match;
   assign wr_pos = n_ff - r_ff - CNT_W'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if ((req_tuser == ACT_REM_FIRST) || (req_tuser == ACT_REM_ALL)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      scan_step  = 1'b0;
      hold_load  = 1'b0;
      case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_SCAN: scan_step  = !scan_done;
         ST_HOLD: hold_load  = out_free;
         default: req_tready = 1'b0;
      endcase
   end

   assign load_data = scan_step ? head : req_tdata;

   // the cell chain
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [VAL_W-1:0] right;
      if (i < DEPTH - 1) begin : g_mid
         assign right = cell_q[i+1];
      end else begin : g_end
         assign right = cell_q[i];
      end

      assign cell_ctl[i].shift = scan_step;
      assign cell_ctl[i].load  = (scan_step && keep && (wr_pos == CNT_W'(i)))
                              || (req_fire && is_append && !full && (count_ff == CNT_W'(i)));

      blir_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl[i]),
         .load_data  (load_data),
         .right_data (right),
         .data       (cell_q[i])
      );
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (req_fire && is_append && !full) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if ((state_ff == ST_SCAN) && scan_done) begin
            count_ff <= n_ff - r_ff;
         end
      end
   end

   // operation context and scan counters
   always_ff @(posedge clock) begin
      if (req_fire) begin
         act_ff <= req_tuser;
         key_ff <= req_tdata;
         rej_ff <= is_append && full;
         n_ff   <= count_ff;
         k_ff   <= '0;
         r_ff   <= '0;
      end else if (scan_step) begin
         k_ff <= k_ff + CNT_W'(1);
         if (match) begin
            r_ff <= r_ff + CNT_W'(1);
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (hold_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (hold_load) begin
         rsp_found_ff <= is_removal && (r_ff != '0);
         rsp_value_ff <= (is_removal && (r_ff != '0)) ? key_ff : '0;
         rsp_count_ff <= count_ff[4:0];
         rsp_rej_ff   <= rej_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_count_ff, rsp_value_ff};
   assign rsp_tuser  = {rsp_rej_ff, rsp_found_ff};

   // the entry count never exceeds capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above capacity");

   // drops never outrun scanned entries, and scanning stops at the snapshot count
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> ((r_ff <= k_ff) && (k_ff <= n_ff)))
      else $error("scan counters out of range");

   // a removal that ends leaves the count reduced by exactly the drops
   a_scan_count: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && scan_done) |=> (count_ff == $past(n_ff - r_ff)))
      else $error("count after removal does not match drops");

   // a rejection only comes from an append
   a_reject_kind: assert property (@(posedge clock) disable iff (reset)
      (hold_load && rej_ff) |-> (act_ff == ACT_APPEND))
      else $error("rejection flagged on a non-append item");

endmodule

@@ bench/bounded_list_insert_remove_top_tb.sv @@
// self-checking bench for the bounded list: directed and random items checked against a queue model
module bounded_list_insert_remove_top_tb
   import blir_pkg::*;
;

   // action code the block treats as no operation
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int RANDOM_OPS = 500;

   // one result as the block reports it
   typedef struct packed {
      logic [VAL_W-1:0] removed_value;
      logic             found;
      logic [CNT_W-1:0] entry_count;
      logic             rejected;
   } list_outcome_type;

   // shadow list and queue of outcomes still owed by the block
   class list_tracker;
      logic [VAL_W-1:0] stored[$];
      list_outcome_type pending[$];
      int               failures;

      // apply one accepted operation to the shadow list and queue its outcome
      function void apply_op(logic [1:0] act, logic [VAL_W-1:0] val);
         list_outcome_type want;
         logic [VAL_W-1:0] kept[$];
         int               hits;
         want = '0;
         case (act)
            ACT_APPEND: begin
               if (stored.size() >= DEPTH) want.rejected = 1'b1;
               else stored.push_back(val);
            end
            ACT_REM_FIRST, ACT_REM_ALL: begin
               hits = 0;
               foreach (stored[i]) begin
                  if (stored[i] == val && (act == ACT_REM_ALL || hits == 0)) hits++;
                  else kept.push_back(stored[i]);
               end
               stored = kept;
               if (hits != 0) begin
                  want.found         = 1'b1;
                  want.removed_value = val;
               end
            end
            default: ;
         endcase
         want.entry_count = CNT_W'(stored.size());
         pending.push_back(want);
      endfunction

      // compare one delivered result with the oldest outcome owed
      function void check_outcome(list_outcome_type got);
         list_outcome_type want;
         if (pending.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected result: removed=%h found=%b count=%0d rejected=%b",
                        got.removed_value, got.found, got.entry_count, got.rejected);
         end else begin
            want = pending.pop_front();
            if (got.removed_value !== want.removed_value || got.found !== want.found ||
                got.entry_count !== want.entry_count || got.rejected !== want.rejected) begin
               failures++;
               if (failures <= 10)
                  $display("mismatch: expected removed=%h found=%b count=%0d rejected=%b, %s",
                           want.removed_value, want.found, want.entry_count, want.rejected,
                           $sformatf("got removed=%h found=%b count=%0d rejected=%b",
                                     got.removed_value, got.found, got.entry_count,
                                     got.rejected));
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] value
   logic [1:0]  req_tuser = '0;   // [1:0] action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // [31:0] removed_value, [36:32] entry_count, [39:37] zero
   logic [1:0]  rsp_tuser;        // [0] found, [1] rejected

   list_tracker tracker = new();
   bit          calm = 1'b0;      // no idling on either side while set

   bounded_list_insert_remove_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // clock
   initial begin
      forever #10 clock = ~clock;
   end

   // idle length: mostly none or short, a few long
   function automatic int pick_idle();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   // present one item at the falling edge and hold it until accepted
   task automatic send_op(logic [1:0] act, logic [31:0] val);
      int gap;
      gap = pick_idle();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         req_tdata  = $urandom();
         req_tuser  = 2'($urandom_range(0, 3));
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = val;
      req_tuser  = act;
      do @(posedge clock); while (!req_tready);
      tracker.apply_op(act, val);
      @(negedge clock);
   endtask

   // result side backpressure
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_tready = 1'b0;
            stall_left = pick_idle();
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_outcome('{rsp_tdata[31:0], rsp_tuser[0], rsp_tdata[36:32], rsp_tuser[1]});
   end

   // stimulus and end of run
   initial begin
      logic [31:0] pool[4];
      logic [1:0]  act;
      logic [31:0] val;
      int          phase_left;
      int          sent;
      int          r;
      bit          filling;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty list: removals find nothing, unused code changes nothing
      send_op(ACT_REM_FIRST, 32'h0000_0000);
      send_op(ACT_REM_ALL, 32'hffff_ffff);
      send_op(ACT_UNUSED, 32'hffff_ffff);
      // fill to capacity with extremes at head and tail, duplicates between
      for (int i = 0; i < DEPTH; i++)
         send_op(ACT_APPEND, (i == 0) ? 32'h8000_0000 :
                             (i == DEPTH - 1) ? 32'h7fff_ffff :
                             (i % 2) ? 32'd7 : 32'd0);
      // full list: append refused, unused code keeps the count
      send_op(ACT_APPEND, 32'hffff_ffff);
      send_op(ACT_UNUSED, 32'h0000_0000);
      // single and bulk removal of duplicates, tail removal, no match
      send_op(ACT_REM_FIRST, 32'd7);
      send_op(ACT_REM_ALL, 32'd7);
      send_op(ACT_REM_FIRST, 32'h7fff_ffff);
      send_op(ACT_REM_ALL, 32'h0001_2345);

      // random phases that alternately grow and drain the list
      filling    = 1'b0;
      phase_left = 0;
      sent       = 0;
      while (sent < RANDOM_OPS) begin
         if (phase_left == 0) begin
            filling    = !filling;
            phase_left = $urandom_range(15, 60);
            calm       = ($urandom_range(0, 3) == 0);
            foreach (pool[k]) begin
               case ($urandom_range(0, 7))
                  0:       pool[k] = 32'h0000_0000;
                  1:       pool[k] = 32'hffff_ffff;
                  2:       pool[k] = 32'h8000_0000;
                  3:       pool[k] = 32'h7fff_ffff;
                  default: pool[k] = $urandom();
               endcase
            end
         end
         phase_left--;
         r = $urandom_range(0, 99);
         if (r < 3) act = ACT_UNUSED;
         else if (r < (filling ? 75 : 28)) act = ACT_APPEND;
         else act = $urandom_range(0, 1) ? ACT_REM_FIRST : ACT_REM_ALL;
         val = ($urandom_range(0, 9) < 8) ? pool[$urandom_range(0, 3)] : $urandom();
         send_op(act, val);
         if (act != ACT_UNUSED) sent++;
      end
      req_tvalid = 1'b0;
      calm       = 1'b0;

      // drain outstanding results, then allow for a late extra one
      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (4 * DEPTH) @(posedge clock);
      if (tracker.failures == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // watchdog
   initial begin
      #8_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
